// ===== design/ps2h_pkg.sv =====
// Shared types, constants and helpers for the PS/2 host link engine.
// No dependencies; every other design file depends on this package.
`default_nettype none

package ps2h_pkg;

  localparam int unsigned FifoDepth  = 64;
  localparam int unsigned FifoAw     = $clog2(FifoDepth);
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);
  localparam int unsigned QueueCw    = $clog2(QueueDepth + 1);

  typedef logic [1:0]        cmd_t;
  typedef logic [7:0]        byte_t;
  typedef logic [9:0]        ms_t;
  typedef logic [8:0]        tx_frame_t;
  typedef logic [3:0]        step_t;
  typedef logic [FifoAw-1:0] ptr_t;

  localparam cmd_t CmdEdge = 2'd0;
  localparam cmd_t CmdTick = 2'd1;
  localparam cmd_t CmdRead = 2'd2;
  localparam cmd_t CmdSend = 2'd3;

  localparam ms_t   TimeoutReset   = 10'd250;
  localparam step_t RxFrameEdges   = 4'd11;
  localparam step_t RxLastDataBit  = 4'd8;
  localparam step_t TxLastDataStep = 4'd9;
  localparam step_t TxReleaseStep  = 4'd10;
  localparam step_t StepOne        = 4'd1;

  typedef enum logic [1:0] {
    OP_EDGE,
    OP_TICK,
    OP_READ,
    OP_SEND
  } op_e;

  typedef struct packed {
    op_e       op;
    logic      data_line;
    tx_frame_t tx_frame;
  } job_t;

  typedef struct packed {
    logic scancode_valid;
    logic drive_data;
    logic tx_busy;
    logic frame_stored;
    logic frame_dropped;
  } status_t;

  function automatic ptr_t ring_next(ptr_t p);
    ptr_t n;
    n = (p == ptr_t'(FifoDepth - 1)) ? '0 : p + 1'b1;
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== design/ps2h_if.sv =====
// Handshake channels of the PS/2 host link engine: items in, results out, config.
// Depends on ps2h_pkg.
`default_nettype none

interface ps2h_item_if;
  logic                  valid;
  logic                  ready;
  ps2h_pkg::cmd_t        command;
  logic                  data_line;
  ps2h_pkg::byte_t       send_value;

  modport source (output valid, command, data_line, send_value, input ready);
  modport sink   (input valid, command, data_line, send_value, output ready);
endinterface

interface ps2h_result_if;
  logic            valid;
  logic            ready;
  ps2h_pkg::byte_t scancode;
  logic            scancode_valid;
  logic            drive_data;
  logic            tx_busy;
  logic            frame_stored;
  logic            frame_dropped;

  modport source (output valid, scancode, scancode_valid, drive_data, tx_busy,
                  frame_stored, frame_dropped, input ready);
  modport sink   (input valid, scancode, scancode_valid, drive_data, tx_busy,
                  frame_stored, frame_dropped, output ready);
endinterface

interface ps2h_cfg_if;
  logic          valid;
  logic          ready;
  ps2h_pkg::ms_t idle_timeout_ms;

  modport source (output valid, idle_timeout_ms, input ready);
  modport sink   (input valid, idle_timeout_ms, output ready);
endinterface

`default_nettype wire

// ===== design/ps2h_front.sv =====
// Front end: accepts items, decodes the command, precomputes the transmit frame
// and holds jobs in a short queue for the back end. Depends on ps2h_pkg, ps2h_if.
`default_nettype none

module ps2h_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  ps2h_item_if.sink        req_i,
  output ps2h_pkg::job_t   job_o,
  output logic             job_valid_o,
  input  logic             job_ready_i
);
  import ps2h_pkg::*;

  typedef logic [QueueAw-1:0] qptr_t;
  typedef logic [QueueCw-1:0] qcnt_t;

  job_t  queue_q [QueueDepth];
  qptr_t wr_ptr_q, wr_ptr_d;
  qptr_t rd_ptr_q, rd_ptr_d;
  qcnt_t count_q, count_d;
  job_t  job_in;
  logic  push, pop;

  always_comb begin
    job_in.data_line = req_i.data_line;
    job_in.tx_frame  = {^req_i.send_value, ~req_i.send_value};
    case (req_i.command)
      CmdEdge: job_in.op = OP_EDGE;
      CmdTick: job_in.op = OP_TICK;
      CmdRead: job_in.op = OP_READ;
      CmdSend: job_in.op = OP_SEND;
      default: job_in.op = OP_EDGE;
    endcase
  end

  assign req_i.ready = (count_q != qcnt_t'(QueueDepth));
  assign push        = req_i.valid && req_i.ready;
  assign job_valid_o = (count_q != '0);
  assign pop         = job_valid_o && job_ready_i;
  assign job_o       = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= job_in;
    end
  end

endmodule

`default_nettype wire

// ===== design/ps2h_back.sv =====
// Back end: receive framing, scancode ring FIFO, transmit sequencer, timeout
// register and the output register. Depends on ps2h_pkg, ps2h_if.
`default_nettype none

module ps2h_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ps2h_pkg::job_t  job_i,
  input  logic            job_valid_i,
  output logic            job_ready_o,
  ps2h_cfg_if.sink        cfg_i,
  ps2h_result_if.source   rsp_o
);
  import ps2h_pkg::*;

  byte_t     fifo_mem [FifoDepth];
  byte_t     rdata_q;

  ms_t       timeout_q;
  step_t     rx_cnt_q, rx_cnt_d;
  byte_t     rx_shift_q, rx_shift_d;
  ms_t       idle_q, idle_d;
  ptr_t      head_q, head_d;
  ptr_t      tail_q, tail_d;
  tx_frame_t tx_frame_q, tx_frame_d;
  step_t     tx_step_q, tx_step_d;
  logic      tx_active_q, tx_active_d;
  logic      drive_q, drive_d;
  logic      rsp_valid_q, rsp_valid_d;
  status_t   status_q, status_d;

  logic      fire;
  logic      mem_we, mem_re;
  ptr_t      wr_addr, rd_addr;
  byte_t     wr_data;

  assign job_ready_o = !rsp_valid_q || rsp_o.ready;
  assign fire        = job_valid_i && job_ready_o;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    rx_cnt_d    = rx_cnt_q;
    rx_shift_d  = rx_shift_q;
    idle_d      = idle_q;
    head_d      = head_q;
    tail_d      = tail_q;
    tx_frame_d  = tx_frame_q;
    tx_step_d   = tx_step_q;
    tx_active_d = tx_active_q;
    drive_d     = drive_q;
    status_d    = '0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    wr_addr     = ring_next(head_q);
    rd_addr     = ring_next(tail_q);
    wr_data     = '0;
    if (fire) begin
      case (job_i.op)
        OP_EDGE: begin
          if (tx_active_q) begin
            tx_step_d = tx_step_q + 1'b1;
            if (tx_step_d >= StepOne && tx_step_d <= TxLastDataStep) begin
              drive_d = tx_frame_q[tx_step_d - StepOne];
            end else if (tx_step_d == TxReleaseStep) begin
              drive_d = 1'b0;
            end else begin
              drive_d     = 1'b0;
              tx_active_d = 1'b0;
            end
          end else begin
            if (idle_q > timeout_q) begin
              rx_cnt_d   = '0;
              rx_shift_d = '0;
            end
            idle_d = '0;
            if (rx_cnt_d >= StepOne && rx_cnt_d <= RxLastDataBit) begin
              rx_shift_d[3'(rx_cnt_d - StepOne)] = job_i.data_line;
            end
            rx_cnt_d = rx_cnt_d + 1'b1;
            if (rx_cnt_d >= RxFrameEdges) begin
              wr_data = rx_shift_d;
              if (wr_addr != tail_q) begin
                mem_we                = 1'b1;
                head_d                = wr_addr;
                status_d.frame_stored = 1'b1;
              end else begin
                status_d.frame_dropped = 1'b1;
              end
              rx_cnt_d   = '0;
              rx_shift_d = '0;
            end
          end
        end
        OP_TICK: begin
          if (idle_q != '1) begin
            idle_d = idle_q + 1'b1;
          end
        end
        OP_READ: begin
          if (tail_q != head_q) begin
            mem_re                  = 1'b1;
            tail_d                  = rd_addr;
            status_d.scancode_valid = 1'b1;
          end
        end
        OP_SEND: begin
          tx_frame_d  = job_i.tx_frame;
          tx_step_d   = '0;
          tx_active_d = 1'b1;
          drive_d     = 1'b1;
        end
        default: ;
      endcase
      status_d.drive_data = drive_d;
      status_d.tx_busy    = tx_active_d;
    end
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (fire) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= TimeoutReset;
      rx_cnt_q    <= '0;
      rx_shift_q  <= '0;
      idle_q      <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      tx_frame_q  <= '0;
      tx_step_q   <= '0;
      tx_active_q <= 1'b0;
      drive_q     <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        timeout_q <= cfg_i.idle_timeout_ms;
      end
      rx_cnt_q    <= rx_cnt_d;
      rx_shift_q  <= rx_shift_d;
      idle_q      <= idle_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      tx_frame_q  <= tx_frame_d;
      tx_step_q   <= tx_step_d;
      tx_active_q <= tx_active_d;
      drive_q     <= drive_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      fifo_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= fifo_mem[rd_addr];
    end
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.scancode       = status_q.scancode_valid ? rdata_q : '0;
  assign rsp_o.scancode_valid = status_q.scancode_valid;
  assign rsp_o.drive_data     = status_q.drive_data;
  assign rsp_o.tx_busy        = status_q.tx_busy;
  assign rsp_o.frame_stored   = status_q.frame_stored;
  assign rsp_o.frame_dropped  = status_q.frame_dropped;

endmodule

`default_nettype wire

// ===== design/ps2_host_rx_tx_fifo_top.sv =====
// PS/2 host link engine, top level: front end, job queue and back end.
// Depends on ps2h_pkg, ps2h_if, ps2h_front, ps2h_back.
//
// Usage:
//   req_i carries one item per handshake: a clock falling edge with the sampled
//   data level, a millisecond tick, a scancode read or a send request.
//   rsp_o returns exactly one result item per accepted item, in order: popped
//   scancode, data-line drive, transfer busy and frame stored/dropped flags.
//   cfg_i writes the idle timeout in milliseconds; it is always ready. It must be
//   written only while no item is in flight; the block does not enforce this.
// Timing:
//   Accepted items pass the job queue, then the back end output register, to
//   rsp_o. One item per cycle is sustained unless rsp_o stalls; the back end
//   updates all state per job, and scancode FIFO read data is registered.
// Reset:
//   Queue and scancode FIFO empty, receive frame and idle count cleared, line
//   released, timeout 250 ms. No clearing pass is needed.
// Stall:
//   When rsp_o is stalled the result holds; the two-entry job queue keeps
//   taking items until it is full, then req_i.ready drops.
`default_nettype none

module ps2_host_rx_tx_fifo_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  ps2h_item_if.sink      req_i,
  ps2h_result_if.source  rsp_o,
  ps2h_cfg_if.sink       cfg_i
);
  import ps2h_pkg::*;

  job_t job;
  logic job_valid;
  logic job_ready;

  ps2h_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .job_o       (job),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready)
  );

  ps2h_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .cfg_i       (cfg_i),
    .rsp_o       (rsp_o)
  );

endmodule

`default_nettype wire

// ===== design/ps2h_checker.sv =====
// Port-level checks for the PS/2 host link engine, bound to the top level.
// Depends on ps2h_pkg and ps2_host_rx_tx_fifo_top.
`default_nettype none

module ps2h_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            rsp_valid_i,
  input logic            rsp_ready_i,
  input ps2h_pkg::byte_t scancode_i,
  input logic            scancode_valid_i,
  input logic            drive_data_i,
  input logic            tx_busy_i,
  input logic            frame_stored_i,
  input logic            frame_dropped_i
);

  a_code_zero_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !scancode_valid_i |-> scancode_i == '0)
    else $error("scancode nonzero without a popped byte");

  a_frame_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !(frame_stored_i && frame_dropped_i)
                    && !((frame_stored_i || frame_dropped_i) && scancode_valid_i))
    else $error("frame flags and read result mixed in one item");

  a_drive_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && drive_data_i |-> tx_busy_i)
    else $error("data line driven outside a transfer");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(scancode_i)
      && $stable(scancode_valid_i) && $stable(drive_data_i) && $stable(tx_busy_i)
      && $stable(frame_stored_i) && $stable(frame_dropped_i))
    else $error("stalled result changed");

endmodule

bind ps2_host_rx_tx_fifo_top ps2h_checker u_ps2h_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .scancode_i       (rsp_o.scancode),
  .scancode_valid_i (rsp_o.scancode_valid),
  .drive_data_i     (rsp_o.drive_data),
  .tx_busy_i        (rsp_o.tx_busy),
  .frame_stored_i   (rsp_o.frame_stored),
  .frame_dropped_i  (rsp_o.frame_dropped)
);

`default_nettype wire

// ===== sim/ps2h_link_checker.sv =====
// Result checker for the PS/2 host link engine: predicts every result and compares.
// Depends on ps2h_pkg and the channel interfaces in ps2h_if.
`timescale 1ns / 100ps

module ps2h_link_checker (
  input  logic   clk_i,
  input  logic   rst_ni,
  ps2h_item_if   req_i,
  ps2h_result_if rsp_i,
  ps2h_cfg_if    cfg_i,
  output int     fail_count_o,
  output int     pending_o,
  output int     items_o,
  output int     stored_o,
  output int     dropped_o,
  output int     popped_o,
  output int     expired_o
);
  import ps2h_pkg::*;

  typedef struct packed {
    byte_t scancode;
    logic  scancode_valid;
    logic  drive_data;
    logic  tx_busy;
    logic  frame_stored;
    logic  frame_dropped;
  } link_result_t;

  ms_t          timeout_ms;
  step_t        rx_count;
  byte_t        rx_byte;
  ms_t          quiet_ms;
  byte_t        scan_ring [FifoDepth];
  ptr_t         wr_ptr;
  ptr_t         rd_ptr;
  tx_frame_t    tx_bits;
  step_t        tx_pos;
  logic         tx_on;
  logic         line_low;
  link_result_t awaited [$];
  int           mismatches;
  int           in_flight;
  int           items;
  int           stored;
  int           dropped;
  int           popped;
  int           expired;

  assign fail_count_o = mismatches;
  assign pending_o    = in_flight;
  assign items_o      = items;
  assign stored_o     = stored;
  assign dropped_o    = dropped;
  assign popped_o     = popped;
  assign expired_o    = expired;

  function automatic ptr_t ring_step(ptr_t p);
    return ptr_t'((int'(p) + 1) % FifoDepth);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic predict_item(cmd_t cmd, logic level, byte_t value);
    link_result_t r;
    ptr_t         nxt;
    r = '0;
    case (cmd)
      CmdEdge: begin
        if (tx_on) begin
          tx_pos = tx_pos + 1'b1;
          if (tx_pos <= TxLastDataStep) begin
            line_low = tx_bits[tx_pos - 1];
          end else begin
            line_low = 1'b0;
            if (tx_pos != TxReleaseStep) tx_on = 1'b0;
          end
        end else begin
          if (quiet_ms > timeout_ms) begin
            if (rx_count != '0) expired++;
            rx_count = '0;
            rx_byte  = '0;
          end
          quiet_ms = '0;
          if (rx_count >= StepOne && rx_count <= RxLastDataBit) rx_byte[rx_count - 1] = level;
          rx_count = rx_count + 1'b1;
          if (rx_count == RxFrameEdges) begin
            nxt = ring_step(wr_ptr);
            if (nxt != rd_ptr) begin
              scan_ring[nxt] = rx_byte;
              wr_ptr         = nxt;
              r.frame_stored = 1'b1;
              stored++;
            end else begin
              r.frame_dropped = 1'b1;
              dropped++;
            end
            rx_count = '0;
            rx_byte  = '0;
          end
        end
      end
      CmdTick: begin
        if (quiet_ms != '1) quiet_ms = quiet_ms + 1'b1;
      end
      CmdRead: begin
        if (rd_ptr != wr_ptr) begin
          rd_ptr           = ring_step(rd_ptr);
          r.scancode       = scan_ring[rd_ptr];
          r.scancode_valid = 1'b1;
          popped++;
        end
      end
      default: begin
        tx_bits  = {^value, ~value};
        tx_pos   = '0;
        tx_on    = 1'b1;
        line_low = 1'b1;
      end
    endcase
    r.drive_data = line_low;
    r.tx_busy    = tx_on;
    awaited.push_back(r);
    items++;
  endtask

  task automatic check_result();
    link_result_t want;
    if (awaited.size() == 0) begin
      report_mismatch("result with nothing outstanding", 1, 0);
      return;
    end
    want = awaited.pop_front();
    if (rsp_i.scancode !== want.scancode)
      report_mismatch("scancode", int'(rsp_i.scancode), int'(want.scancode));
    if (rsp_i.scancode_valid !== want.scancode_valid)
      report_mismatch("scancode_valid", int'(rsp_i.scancode_valid),
                      int'(want.scancode_valid));
    if (rsp_i.drive_data !== want.drive_data)
      report_mismatch("drive_data", int'(rsp_i.drive_data), int'(want.drive_data));
    if (rsp_i.tx_busy !== want.tx_busy)
      report_mismatch("tx_busy", int'(rsp_i.tx_busy), int'(want.tx_busy));
    if (rsp_i.frame_stored !== want.frame_stored)
      report_mismatch("frame_stored", int'(rsp_i.frame_stored), int'(want.frame_stored));
    if (rsp_i.frame_dropped !== want.frame_dropped)
      report_mismatch("frame_dropped", int'(rsp_i.frame_dropped), int'(want.frame_dropped));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_ms = TimeoutReset;
      rx_count   = '0;
      rx_byte    = '0;
      quiet_ms   = '0;
      wr_ptr     = '0;
      rd_ptr     = '0;
      tx_bits    = '0;
      tx_pos     = '0;
      tx_on      = 1'b0;
      line_low   = 1'b0;
      awaited.delete();
      mismatches = 0;
      items      = 0;
      stored     = 0;
      dropped    = 0;
      popped     = 0;
      expired    = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) timeout_ms = cfg_i.idle_timeout_ms;
      if (rsp_i.valid && rsp_i.ready) check_result();
      if (req_i.valid && req_i.ready)
        predict_item(req_i.command, req_i.data_line, req_i.send_value);
    end
    in_flight = awaited.size();
  end

endmodule

// ===== sim/tb_ps2_host_rx_tx_fifo_top.sv =====
// Testbench top for the PS/2 host link engine: clock, reset, stimulus and verdict.
// Depends on ps2h_pkg, ps2h_if, ps2_host_rx_tx_fifo_top and ps2h_link_checker.
`timescale 1ns / 100ps

module tb_ps2_host_rx_tx_fifo_top;
  import ps2h_pkg::*;

  localparam int StallLimit  = 1000;
  localparam int DrainCycles = 20;

  logic clk_i;
  logic rst_ni;
  bit   idle_on;
  int   stall_left;
  int   quiet_cycles;
  int   fail_count;
  int   pending;
  int   item_count;
  int   stored_count;
  int   dropped_count;
  int   popped_count;
  int   expired_count;

  ps2h_item_if   req ();
  ps2h_result_if rsp ();
  ps2h_cfg_if    cfg ();

  ps2_host_rx_tx_fifo_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp),
    .cfg_i  (cfg)
  );

  ps2h_link_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req),
    .rsp_i        (rsp),
    .cfg_i        (cfg),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .items_o      (item_count),
    .stored_o     (stored_count),
    .dropped_o    (dropped_count),
    .popped_o     (popped_count),
    .expired_o    (expired_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    rsp.ready  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        rsp.ready = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);
        rsp.ready  = 1'b0;
      end else begin
        rsp.ready = 1'b1;
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("tb_ps2_host_rx_tx_fifo_top failed");
    $finish;
  end

  task automatic put_item(cmd_t c, logic level, byte_t v);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req.valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    req.valid      = 1'b1;
    req.command    = c;
    req.data_line  = level;
    req.send_value = v;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic put_ticks(int n);
    repeat (n) put_item(CmdTick, 1'($urandom_range(0, 1)), byte_t'($urandom));
  endtask

  task automatic put_frame(byte_t b, int tick_odds);
    logic [10:0] bits;
    bits = {1'b1, ~^b, b, 1'b0};
    for (int i = 0; i < 11; i++) begin
      if (tick_odds != 0 && $urandom_range(1, tick_odds) == 1) put_ticks($urandom_range(1, 4));
      put_item(CmdEdge, bits[i], byte_t'($urandom));
    end
  endtask

  task automatic put_send(byte_t v);
    int cut;
    do begin
      put_item(CmdSend, 1'($urandom_range(0, 1)), v);
      cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 10) : 11;
      repeat (cut) put_item(CmdEdge, 1'($urandom_range(0, 1)), byte_t'($urandom));
      v = byte_t'($urandom);
    end while (cut < 11);
  endtask

  task automatic put_reads(int n);
    repeat (n) put_item(CmdRead, 1'($urandom_range(0, 1)), byte_t'($urandom));
  endtask

  task automatic wait_quiet();
    req.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_timeout(ms_t v);
    wait_quiet();
    cfg.valid           = 1'b1;
    cfg.idle_timeout_ms = v;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg.valid = 1'b0;
  endtask

  task automatic mixed_phase(int units, int tick_odds);
    int pick;
    for (int u = 0; u < units; u++) begin
      if (u == units / 2) wait_quiet();
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        put_frame(byte_t'($urandom), tick_odds);
      end else if (pick < 75) begin
        put_reads(1);
      end else if (pick < 85) begin
        put_send(byte_t'($urandom));
      end else if (pick < 92) begin
        put_item(cmd_t'($urandom), 1'($urandom_range(0, 1)), byte_t'($urandom));
      end else begin
        repeat ($urandom_range(1, 10))
          put_item(CmdEdge, 1'($urandom_range(0, 1)), byte_t'($urandom));
        put_ticks($urandom_range(0, 5));
      end
    end
  endtask

  initial begin
    idle_on             = 1'b1;
    rst_ni              = 1'b0;
    req.valid           = 1'b0;
    req.command         = CmdTick;
    req.data_line       = 1'b0;
    req.send_value      = '0;
    cfg.valid           = 1'b0;
    cfg.idle_timeout_ms = TimeoutReset;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    put_item(CmdRead, 1'b1, 8'hFF);
    put_item(CmdTick, 1'b1, 8'h00);
    put_item(CmdSend, 1'b0, 8'h00);
    repeat (3) put_item(CmdEdge, 1'b1, 8'hFF);
    put_item(CmdSend, 1'b1, 8'hFF);
    repeat (11) put_item(CmdEdge, 1'b0, 8'h00);
    put_item(CmdRead, 1'b0, 8'h00);

    write_timeout(10'd1);
    mixed_phase(6, 6);
    write_timeout(10'd0);
    mixed_phase(6, 6);
    write_timeout(ms_t'($urandom_range(2, 6)));
    mixed_phase(6, 6);

    // fill the scancode FIFO past full, then drain it
    write_timeout(10'd1023);
    put_send(byte_t'($urandom));
    put_reads(64);
    repeat (65) put_frame(byte_t'($urandom), 0);
    put_reads(64);

    // hold a partial frame across ticks well inside the longest timeout
    repeat (3) put_item(CmdEdge, 1'($urandom_range(0, 1)), byte_t'($urandom));
    put_ticks(20);
    repeat (8) put_item(CmdEdge, 1'($urandom_range(0, 1)), byte_t'($urandom));
    put_reads(2);

    write_timeout(TimeoutReset);
    idle_on = 1'b0;
    mixed_phase(6, 0);

    wait_quiet();
    repeat (DrainCycles) @(negedge clk_i);
    $display("Run covered %0d items: %0d frames stored, %0d dropped on a full FIFO,",
             item_count, stored_count, dropped_count);
    $display("%0d scancodes read back, %0d partial frames discarded after idle timeout.",
             popped_count, expired_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_ps2_host_rx_tx_fifo_top passed");
    end else begin
      $display("tb_ps2_host_rx_tx_fifo_top failed");
    end
    $finish;
  end

endmodule
